### design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies an outcome in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

### design/hme_pkg.sv
// Package: widths and types of the minimum-eigenvalue pipeline.
`timescale 1ns / 1ps
`default_nettype none
package hme_pkg;

  localparam int IN_WIDTH  = 32;
  localparam int OUT_WIDTH = 34;
  localparam int SUM_W     = IN_WIDTH + 1;
  localparam int MAG_W     = IN_WIDTH + 1;
  localparam int RAD_W     = 2 * MAG_W;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int REM_W     = ROOT_W + 2;
  localparam int DIFF_W    = (IN_WIDTH + 3 > OUT_WIDTH + 1) ? IN_WIDTH + 3 : OUT_WIDTH + 1;

  typedef logic signed [IN_WIDTH-1:0]  in_word_t;
  typedef logic signed [OUT_WIDTH-1:0] eig_t;
  typedef logic signed [SUM_W-1:0]     sum_t;
  typedef logic        [MAG_W-1:0]     mag_t;
  typedef logic        [IN_WIDTH-1:0]  cmag_t;
  typedef logic        [RAD_W-1:0]     rad_t;
  typedef logic        [ROOT_W-1:0]    root_t;
  typedef logic        [REM_W-1:0]     rem_t;
  typedef logic signed [DIFF_W-1:0]    diff_t;

endpackage
`default_nettype wire

### design/hme_stream_if.sv
// Interfaces: request channels for pixel terms and eigenvalue results.
`timescale 1ns / 1ps
`default_nettype none
interface hme_in_if;
  import hme_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t second_x;
  in_word_t second_y;
  in_word_t second_cross;

  modport source (output valid, output second_x, output second_y, output second_cross,
                  input ready);
  modport sink   (input valid, input second_x, input second_y, input second_cross,
                  output ready);
endinterface

interface hme_out_if;
  import hme_pkg::*;

  logic valid;
  logic ready;
  eig_t min_eigen;

  modport source (output valid, output min_eigen, input ready);
  modport sink   (input valid, input min_eigen, output ready);
endinterface
`default_nettype wire

### design/hessian_min_eigenvalue_top.sv
// Throughput: one pixel per cycle while the skid stage is empty; the root
// takes one result bit per stage. Path: s1, s2, s3, root stages, output.
// A two-entry output register and skid stage keep taking requests while
// one result waits; in_ch.ready drops only when both are full.
// Reset clears all valid bits; payload registers are not reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module hessian_min_eigenvalue_top (
  input  wire        clk,
  input  wire        rst_n,
  hme_in_if.sink     in_ch,
  hme_out_if.source  out_ch
);
  import hme_pkg::*;

  logic  en;
  logic  skid_v_r;
  logic  skid_v_nxt;
  eig_t  skid_d_r;
  eig_t  skid_d_nxt;
  logic  out_v_r;
  logic  out_v_nxt;
  eig_t  out_d_r;
  eig_t  out_d_nxt;

  sum_t  s1_sum_nxt;
  sum_t  s1_dif;
  mag_t  s1_dmag_nxt;
  cmag_t s1_cmag_nxt;
  logic  s1_v_r;
  sum_t  s1_sum_r;
  mag_t  s1_dmag_r;
  cmag_t s1_cmag_r;

  rad_t  s2_dsq_nxt;
  logic [2*IN_WIDTH-1:0] s2_csq_nxt;
  logic  s2_v_r;
  sum_t  s2_sum_r;
  rad_t  s2_dsq_r;
  logic [2*IN_WIDTH-1:0] s2_csq_r;

  rad_t  s3_rad_nxt;
  logic  s3_v_r;
  sum_t  s3_sum_r;
  rad_t  s3_rad_r;

  logic  tail_v;
  root_t tail_root;
  sum_t  tail_sum;
  diff_t tail_diff;
  eig_t  tail_d;
  logic  pass;

  assign en          = !skid_v_r;
  assign in_ch.ready = en;

  assign s1_sum_nxt  = sum_t'(in_ch.second_x) + sum_t'(in_ch.second_y);
  assign s1_dif      = sum_t'(in_ch.second_x) - sum_t'(in_ch.second_y);
  assign s1_dmag_nxt = s1_dif[SUM_W-1] ? mag_t'(~s1_dif + 1'b1) : mag_t'(s1_dif);
  assign s1_cmag_nxt = in_ch.second_cross[IN_WIDTH-1] ?
                       cmag_t'(~in_ch.second_cross + 1'b1) : cmag_t'(in_ch.second_cross);

  assign s2_dsq_nxt  = rad_t'(s1_dmag_r) * rad_t'(s1_dmag_r);
  assign s2_csq_nxt  = (2*IN_WIDTH)'(s1_cmag_r) * (2*IN_WIDTH)'(s1_cmag_r);

  assign s3_rad_nxt  = s2_dsq_r + {s2_csq_r, 2'b00};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_ch.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sum_r  <= s1_sum_nxt;
      s1_dmag_r <= s1_dmag_nxt;
      s1_cmag_r <= s1_cmag_nxt;
      s2_sum_r  <= s1_sum_r;
      s2_dsq_r  <= s2_dsq_nxt;
      s2_csq_r  <= s2_csq_nxt;
      s3_sum_r  <= s2_sum_r;
      s3_rad_r  <= s3_rad_nxt;
    end
  end

  hme_isqrt_pipe u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_rad    (s3_rad_r),
    .in_sum    (s3_sum_r),
    .out_valid (tail_v),
    .out_root  (tail_root),
    .out_sum   (tail_sum)
  );

  assign tail_diff = diff_t'(tail_sum) - diff_t'(tail_root);
  assign tail_d    = tail_diff[OUT_WIDTH:1];
  assign pass      = en && tail_v;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (!out_v_r || out_ch.ready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = pass;
        out_d_nxt = tail_d;
      end
    end else if (pass) begin
      skid_v_nxt = 1'b1;
      skid_d_nxt = tail_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.min_eigen = out_d_r;

  `ASSERT_ALWAYS(a_skid_behind_out, clk, rst_n, !skid_v_r || out_v_r, "skid full, output empty")
  `ASSERT_NEXT(a_skid_capture, clk, rst_n, out_v_r && !out_ch.ready && pass, skid_v_r, "result lost")
  `ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_v_r && out_ch.ready, !skid_v_r && out_v_r, "skid stuck")

endmodule
`default_nettype wire

### design/hme_isqrt_pipe.sv
// Pipelined truncated integer square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module hme_isqrt_pipe (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            en,
  input  wire            in_valid,
  input  hme_pkg::rad_t  in_rad,
  input  hme_pkg::sum_t  in_sum,
  output logic           out_valid,
  output hme_pkg::root_t out_root,
  output hme_pkg::sum_t  out_sum
);
  import hme_pkg::*;

  logic  v_r    [ROOT_W];
  rad_t  rad_r  [ROOT_W];
  rem_t  rem_r  [ROOT_W];
  root_t root_r [ROOT_W];
  sum_t  sum_r  [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_step
    logic  pv;
    rad_t  prad;
    rem_t  prem;
    root_t proot;
    sum_t  psum;
    rem_t  rem_sh;
    rem_t  trial;
    logic  take;
    rad_t  rad_nxt;
    rem_t  rem_nxt;
    root_t root_nxt;

    if (i == 0) begin : g_first
      assign pv    = in_valid;
      assign prad  = in_rad;
      assign prem  = '0;
      assign proot = '0;
      assign psum  = in_sum;
    end else begin : g_next
      assign pv    = v_r[i-1];
      assign prad  = rad_r[i-1];
      assign prem  = rem_r[i-1];
      assign proot = root_r[i-1];
      assign psum  = sum_r[i-1];
    end

    assign rem_sh   = {prem[REM_W-3:0], prad[RAD_W-1 -: 2]};
    assign trial    = {proot, 2'b01};
    assign take     = (rem_sh >= trial);
    assign rad_nxt  = {prad[RAD_W-3:0], 2'b00};
    assign rem_nxt  = take ? (rem_sh - trial) : rem_sh;
    assign root_nxt = {proot[ROOT_W-2:0], take};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= pv;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad_r[i]  <= rad_nxt;
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        sum_r[i]  <= psum;
      end
    end
  end

  assign out_valid = v_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];
  assign out_sum   = sum_r[ROOT_W-1];

endmodule
`default_nettype wire

### sim/hessian_min_eigenvalue_top_tb.sv
// Testbench: checks the 2x2 minimum-eigenvalue pipeline against a bit-exact predictor.
`timescale 1ns / 1ps
`default_nettype none
module hessian_min_eigenvalue_top_tb;
  import hme_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 48;
  localparam int RANDOM_ITEMS = 1800;

  localparam in_word_t TERM_MAX  = in_word_t'(32'h7FFF_FFFF);
  localparam in_word_t TERM_MIN  = in_word_t'(32'h8000_0000);
  localparam in_word_t TERM_ONE  = in_word_t'(32'h0001_0000);
  localparam in_word_t TERM_LSB  = in_word_t'(32'h0000_0001);
  localparam in_word_t TERM_NEG1 = in_word_t'(32'hFFFF_FFFF);

  class eigen_scoreboard;
    eig_t        pending_eigen[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    function eig_t predict_min_eigen(in_word_t dxx, in_word_t dyy, in_word_t dxy);
      logic signed [35:0] trace_s;
      logic signed [35:0] spread;
      logic signed [35:0] cross_s;
      logic signed [35:0] lowered;
      logic signed [35:0] halved;
      logic [33:0]        spread_mag;
      logic [33:0]        cross_mag;
      logic [33:0]        root;
      logic [33:0]        cand;
      logic [67:0]        radicand;
      trace_s = $signed({{4{dxx[31]}}, dxx}) + $signed({{4{dyy[31]}}, dyy});
      spread  = $signed({{4{dxx[31]}}, dxx}) - $signed({{4{dyy[31]}}, dyy});
      cross_s = $signed({{4{dxy[31]}}, dxy});
      spread_mag = spread[35] ? 34'(-spread) : spread[33:0];
      cross_mag  = cross_s[35] ? 34'(-cross_s) : cross_s[33:0];
      radicand = 68'(spread_mag) * 68'(spread_mag)
               + ((68'(cross_mag) * 68'(cross_mag)) << 2);
      root = '0;
      for (int b = 33; b >= 0; b--) begin
        cand = root | (34'd1 << b);
        if (68'(cand) * 68'(cand) <= radicand) root = cand;
      end
      lowered = trace_s - $signed({2'b00, root});
      halved  = lowered >>> 1;
      return eig_t'(halved[33:0]);
    endfunction

    task report_mismatch(string what, eig_t got, eig_t want);
      $display("mismatch %s: min_eigen got %0d expected %0d", what, got, want);
      mismatches++;
    endtask

    function void note_request(in_word_t dxx, in_word_t dyy, in_word_t dxy);
      eig_t want;
      want = predict_min_eigen(dxx, dyy, dxy);
      pending_eigen = {pending_eigen, want};
    endfunction

    task check_result(eig_t got);
      eig_t want;
      if (pending_eigen.size() == 0) begin
        report_mismatch("unexpected result", got, '0);
      end else begin
        want = pending_eigen.pop_front();
        if (got !== want) report_mismatch("value", got, want);
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   in_idle_pct;
  int   out_idle_pct;
  int   cycles;
  eigen_scoreboard sb;

  hme_in_if  in_ch ();
  hme_out_if out_ch ();

  hessian_min_eigenvalue_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("hessian_min_eigenvalue_top_tb NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_result(out_ch.min_eigen);
    out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  task automatic send_pixel(input in_word_t dxx, input in_word_t dyy, input in_word_t dxy);
    if ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < in_idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.second_x     <= dxx;
    in_ch.second_y     <= dyy;
    in_ch.second_cross <= dxy;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(dxx, dyy, dxy);
  endtask

  function automatic in_word_t rand_term();
    in_word_t term;
    case ($urandom_range(0, 5))
      0, 1: term = in_word_t'($urandom);
      2: term = in_word_t'(int'($urandom_range(0, 1023)) - 512);
      3: begin
        case ($urandom_range(0, 4))
          0: term = TERM_MIN;
          1: term = TERM_MAX;
          2: term = '0;
          3: term = TERM_NEG1;
          default: term = TERM_LSB;
        endcase
      end
      4: term = in_word_t'((int'($urandom_range(0, 400)) - 200) <<< 16);
      default: term = in_word_t'(int'(shortint'($urandom)));
    endcase
    return term;
  endfunction

  initial begin
    clk                = 1'b0;
    rst_n              = 1'b0;
    cycles             = 0;
    in_idle_pct        = 27;
    out_idle_pct       = 79;
    in_ch.valid        = 1'b0;
    in_ch.second_x     = '0;
    in_ch.second_y     = '0;
    in_ch.second_cross = '0;
    out_ch.ready       = 1'b0;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_pixel('0, '0, '0);
    send_pixel(TERM_MAX, TERM_MAX, TERM_MAX);
    send_pixel(TERM_MIN, TERM_MIN, TERM_MIN);
    send_pixel(TERM_MAX, TERM_MIN, TERM_MIN);
    send_pixel(TERM_MIN, TERM_MAX, TERM_MIN);
    send_pixel(TERM_MAX, TERM_MIN, TERM_MAX);
    send_pixel(TERM_MIN, TERM_MIN, '0);
    send_pixel(TERM_MAX, TERM_MAX, '0);
    send_pixel('0, '0, TERM_MIN);
    send_pixel('0, '0, TERM_MAX);
    send_pixel(TERM_NEG1, '0, '0);
    send_pixel('0, TERM_NEG1, '0);
    send_pixel(TERM_LSB, '0, '0);
    send_pixel('0, '0, TERM_LSB);
    send_pixel(TERM_NEG1, TERM_NEG1, TERM_NEG1);
    send_pixel(TERM_ONE, TERM_ONE, TERM_ONE);
    send_pixel(in_word_t'(3 * 65536), in_word_t'(-(1 * 65536)), in_word_t'(2 * 65536));
    send_pixel(in_word_t'(-(5 * 65536)), in_word_t'(7 * 65536), TERM_NEG1);
    send_pixel(TERM_ONE, TERM_NEG1, TERM_LSB);
    send_pixel(in_word_t'(32'h5555_5555), in_word_t'(32'hAAAA_AAAA),
               in_word_t'(32'h5555_5555));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        in_idle_pct  = 79;
        out_idle_pct = 27;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        in_idle_pct  = 0;
        out_idle_pct = 0;
      end
      send_pixel(rand_term(), rand_term(), rand_term());
    end
    in_ch.valid <= 1'b0;

    while (sb.pending_eigen.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending_eigen.size() == 0) begin
      $display("hessian_min_eigenvalue_top_tb OK");
    end else begin
      $display("hessian_min_eigenvalue_top_tb NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
